FILE: rtl/thw_pkg.sv
// ----------------------------------------------------------------------------
// thw_pkg
// Shared types and constants of the archive header walker: transaction
// structs, walker state, phase codes and header field offsets.
// ----------------------------------------------------------------------------
package thw_pkg;

  localparam int          OFF_W       = 9;
  localparam int          COUNT_W     = 23;
  localparam int          MODE_W      = 9;
  localparam int          SIZE_W      = 32;
  localparam int          FIFO_DEPTH  = 4;

  localparam logic [OFF_W-1:0]   MODE_OFFSET = 9'd100;
  localparam logic [OFF_W-1:0]   SIZE_OFFSET = 9'd124;
  localparam logic [OFF_W-1:0]   BLOCK_LAST  = 9'd511;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 23'h7F_FFFF;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_ENDED  = 2'd2;

  localparam logic KIND_FILE  = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic [MODE_W-1:0]  file_mode;
    logic [SIZE_W-1:0]  file_size;
    logic [COUNT_W-1:0] file_count;
    logic               run_end;
  } out_t;

  typedef struct packed {
    logic [OFF_W-1:0]   block_offset;
    logic [1:0]         phase;
    logic [COUNT_W-1:0] blocks_to_skip;
    logic [MODE_W-1:0]  mode_accum;
    logic [SIZE_W-1:0]  size_accum;
    logic               mode_parsing;
    logic               size_parsing;
    logic [COUNT_W-1:0] entry_count;
  } state_t;

  localparam state_t STATE_RESET = '{
    block_offset:   '0,
    phase:          PH_HEADER,
    blocks_to_skip: '0,
    mode_accum:     '0,
    size_accum:     '0,
    mode_parsing:   1'b0,
    size_parsing:   1'b0,
    entry_count:    '0
  };

endpackage

FILE: rtl/tar_header_walker_core.sv
// ----------------------------------------------------------------------------
// tar_header_walker_core
// Archive header walker: parses mode and size of each header block, skips
// the payload blocks and reports file entries and the archive total.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the input is not stalled; a byte that
// ends a header and is flagged last yields two results, drained one per cycle
// through a FIFO_DEPTH queue while out_stall is low.
// Input stalls only while the result queue has fewer than two free entries.
// Reset (synchronous, rst_n low): walker state, input stage and queue clear.
module tar_header_walker_core #(
  parameter int FIFO_DEPTH = thw_pkg::FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  thw_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output thw_pkg::out_t out_data
);
  import thw_pkg::*;

  logic       s1_vld_r;
  in_t        s1_r;
  state_t     st_r;
  state_t     st_nxt;
  logic [1:0] res_n;
  out_t       res0;
  out_t       res1;
  logic       room2;
  logic       s1_fire;
  logic       in_acc;
  logic [1:0] push_n;

  assign s1_fire  = s1_vld_r && room2;
  assign in_stall = s1_vld_r && !room2;
  assign in_acc   = in_valid && !in_stall;
  assign push_n   = s1_fire ? res_n : 2'd0;

  thw_step u_step (
    .cur   (st_r),
    .item  (s1_r),
    .nxt   (st_nxt),
    .res_n (res_n),
    .res0  (res0),
    .res1  (res1)
  );

  thw_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push0     (res0),
    .push1     (res1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      st_r     <= STATE_RESET;
    end else begin
      if (in_acc) s1_vld_r <= 1'b1;
      else if (s1_fire) s1_vld_r <= 1'b0;
      if (s1_fire) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_r <= in_data;
  end

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_r.is_last |=> (st_r.block_offset == '0) && (st_r.entry_count == '0)
      && (st_r.phase == PH_HEADER))
    else $error("walker state not cleared after last byte");

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_r.is_last |-> (res_n != 2'd0))
    else $error("last byte produced no total");

  a_offset_adv: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !s1_r.is_last |=> st_r.block_offset == $past(st_r.block_offset) + 1'b1)
    else $error("block offset did not advance");

endmodule

FILE: rtl/thw_step.sv
// ----------------------------------------------------------------------------
// thw_step
// Per-byte walker logic: next walker state and up to two ordered results
// for one archive byte.
// ----------------------------------------------------------------------------
module thw_step (
  input  thw_pkg::state_t cur,
  input  thw_pkg::in_t    item,
  output thw_pkg::state_t nxt,
  output logic [1:0]      res_n,
  output thw_pkg::out_t   res0,
  output thw_pkg::out_t   res1
);
  import thw_pkg::*;

  logic                octal;
  logic [2:0]          digit;
  logic                block_end;
  logic                has_file;
  logic [COUNT_W:0]    blocks;
  logic [COUNT_W:0]    blocks_m1;
  out_t                file_res;
  out_t                total_res;

  assign octal     = (item.data_byte >= CHAR_ZERO) && (item.data_byte <= CHAR_SEVEN);
  assign digit     = octal ? item.data_byte[2:0] : 3'd0;
  assign block_end = (cur.block_offset == BLOCK_LAST);

  always_comb begin
    nxt       = cur;
    has_file  = 1'b0;
    file_res  = '0;
    total_res = '0;
    blocks    = '0;
    blocks_m1 = '0;
    res_n     = 2'd0;
    res0      = '0;
    res1      = '0;

    case (cur.phase)
      PH_HEADER: begin
        if (cur.block_offset == '0) begin
          nxt.mode_parsing = 1'b0;
          nxt.size_parsing = 1'b0;
        end
        if ((cur.block_offset == '0) && (item.data_byte == 8'd0)) begin
          nxt.phase = PH_ENDED;
        end else begin
          if (cur.block_offset == MODE_OFFSET) begin
            nxt.mode_accum   = '0;
            nxt.mode_parsing = 1'b1;
          end
          if (cur.block_offset == SIZE_OFFSET) begin
            nxt.size_accum   = '0;
            nxt.size_parsing = 1'b1;
          end
          if (nxt.mode_parsing) begin
            if (octal) nxt.mode_accum = {nxt.mode_accum[MODE_W-4:0], digit};
            else       nxt.mode_parsing = 1'b0;
          end
          if (nxt.size_parsing) begin
            if (octal) nxt.size_accum = {nxt.size_accum[SIZE_W-4:0], digit};
            else       nxt.size_parsing = 1'b0;
          end
          if (block_end) begin
            if (nxt.entry_count != COUNT_MAX) begin
              nxt.entry_count = nxt.entry_count + 1'b1;
            end
            has_file            = 1'b1;
            file_res.kind       = KIND_FILE;
            file_res.file_mode  = nxt.mode_accum;
            file_res.file_size  = nxt.size_accum;
            file_res.file_count = nxt.entry_count;
            file_res.run_end    = ~item.is_last;
            blocks    = {1'b0, nxt.size_accum[SIZE_W-1:OFF_W]}
                        + {{COUNT_W{1'b0}}, |nxt.size_accum[OFF_W-1:0]};
            blocks_m1 = blocks - 1'b1;
            if (blocks == '0) begin
              nxt.phase = PH_HEADER;
            end else begin
              nxt.phase          = PH_SKIP;
              nxt.blocks_to_skip = blocks_m1[COUNT_W-1:0];
            end
            nxt.mode_parsing = 1'b0;
            nxt.size_parsing = 1'b0;
          end
        end
      end
      PH_SKIP: begin
        if (block_end) begin
          if (cur.blocks_to_skip == '0) nxt.phase = PH_HEADER;
          else nxt.blocks_to_skip = cur.blocks_to_skip - 1'b1;
        end
      end
      default: begin
      end
    endcase

    nxt.block_offset = cur.block_offset + 1'b1;

    total_res.kind       = KIND_TOTAL;
    total_res.file_count = nxt.entry_count;
    total_res.run_end    = 1'b1;

    if (has_file) begin
      res0  = file_res;
      res_n = 2'd1;
    end
    if (item.is_last) begin
      if (has_file) begin
        res1  = total_res;
        res_n = 2'd2;
      end else begin
        res0  = total_res;
        res_n = 2'd1;
      end
      nxt = STATE_RESET;
    end
  end

endmodule

FILE: rtl/thw_out_fifo.sv
// ----------------------------------------------------------------------------
// thw_out_fifo
// Result queue: takes up to two results per cycle, hands out one per
// transaction on the result channel.
// ----------------------------------------------------------------------------
module thw_out_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_n,
  input  thw_pkg::out_t push0,
  input  thw_pkg::out_t push1,
  output logic          room2,
  output logic          out_valid,
  output thw_pkg::out_t out_data,
  input  logic          out_stall
);
  import thw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_t             mem [DEPTH];
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] wp_nxt;
  logic [PTR_W-1:0] wp1;
  logic [PTR_W-1:0] rp_r;
  logic [PTR_W-1:0] rp_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  assign wp1       = ptr_inc(wp_r);
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rp_r];
  assign pop       = out_valid && !out_stall;
  assign room2     = (cnt_r <= CNT_W'(DEPTH - 2));

  always_comb begin
    case (push_n)
      2'd1:    wp_nxt = wp1;
      2'd2:    wp_nxt = ptr_inc(wp1);
      default: wp_nxt = wp_r;
    endcase
    rp_nxt  = pop ? ptr_inc(rp_r) : rp_r;
    cnt_nxt = cnt_r + CNT_W'(push_n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wp_r] <= push0;
    if (push_n == 2'd2) mem[wp1]  <= push1;
  end

endmodule
